@@ rtl/core/lpcp_pkg.sv @@
// -----------------------------------------------------------------------------
// lpcp_pkg: shared types and constants for lidar point projection
// Holds field widths, register codes, the divider flag struct and the
// rainbow color table that is built at elaboration.
// -----------------------------------------------------------------------------
package lpcp_pkg;

  localparam int unsigned COEFF_W    = 18;
  localparam int unsigned TRANS_W    = 21;
  localparam int unsigned INTR_W     = 21;
  localparam int unsigned POINT_W    = 19;
  localparam int unsigned CAM_FRAC   = 8;
  localparam int unsigned RANGE_W    = 18;
  localparam int unsigned REG_ADDR_W = 6;
  localparam int unsigned CFG_DATA_W = 64;
  localparam int unsigned INTENS_W   = 8;

  localparam logic [RANGE_W-1:0] RANGE_RESET = RANGE_W'(15000);

  // Rainbow ramp constants.
  localparam int unsigned HUE_SPAN     = 179;
  localparam int unsigned HUE_SEGMENTS = 5;
  localparam int unsigned CHAN_MAX     = 255;

  // Configuration register codes, in address order.
  typedef enum logic [2:0] {
    REG_ROT_X,
    REG_ROT_Y,
    REG_ROT_Z,
    REG_TRANS,
    REG_FOCAL,
    REG_PRINCIPAL,
    REG_MAX_RANGE,
    REG_IMAGE_SIZE
  } reg_idx_e;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  typedef rgb_t [255:0] rgb_lut_t;

  // Quotient overflow flags travelling through the divider.
  typedef struct packed {
    logic ovf_col;
    logic ovf_row;
  } div_flags_t;

  // Builds the five-segment hue ramp over intensity.
  function automatic rgb_lut_t build_rainbow();
    rgb_lut_t    lut;
    int unsigned k;
    int unsigned t;
    int unsigned seg;
    int unsigned rem;
    int unsigned a;
    int unsigned n;
    logic [7:0]  nv;
    for (int i = 0; i < 256; i++) begin
      k = (i == 0) ? 0 : i - 1;
      if (k > HUE_SPAN) k = HUE_SPAN;
      t   = HUE_SEGMENTS * k;
      seg = 1 + t / HUE_SPAN;
      rem = t % HUE_SPAN;
      a   = seg[0] ? rem : HUE_SPAN - rem;
      n   = CHAN_MAX * (HUE_SPAN - a) / HUE_SPAN;
      nv  = n[7:0];
      case (seg)
        1: lut[i] = '{red: nv, green: 8'd0, blue: 8'(CHAN_MAX)};
        2: lut[i] = '{red: 8'd0, green: nv, blue: 8'(CHAN_MAX)};
        3: lut[i] = '{red: 8'd0, green: 8'(CHAN_MAX), blue: nv};
        4: lut[i] = '{red: nv, green: 8'(CHAN_MAX), blue: 8'd0};
        default: lut[i] = '{red: 8'(CHAN_MAX), green: nv, blue: 8'd0};
      endcase
    end
    return lut;
  endfunction

  localparam rgb_lut_t RAINBOW_LUT = build_rainbow();

endpackage

@@ rtl/core/lpcp_div.sv @@
// -----------------------------------------------------------------------------
// lpcp_div: pipelined restoring divider for column and row
// Divides two unsigned magnitudes by one shared denominator, one quotient
// bit per stage, and flags quotients that do not fit in Q_W bits.
// -----------------------------------------------------------------------------
module lpcp_div #(
  parameter int unsigned MAG_W = 54,
  parameter int unsigned DEN_W = 38,
  parameter int unsigned Q_W   = 13,
  parameter int unsigned PAY_W = 26
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [MAG_W-1:0]     num_col_i,
  input  logic [MAG_W-1:0]     num_row_i,
  input  logic [DEN_W-1:0]     den_i,
  input  logic [PAY_W-1:0]     pay_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [Q_W-1:0]       q_col_o,
  output logic [Q_W-1:0]       q_row_o,
  output lpcp_pkg::div_flags_t flags_o,
  output logic [PAY_W-1:0]     pay_o
);
  import lpcp_pkg::*;

  localparam int unsigned CMP_W = (MAG_W > DEN_W + Q_W) ? MAG_W : DEN_W + Q_W;

  logic [Q_W-1:0]   v_q;
  logic [Q_W:0]     rdy;
  logic [CMP_W-1:0] rc_q  [Q_W-1];
  logic [CMP_W-1:0] rr_q  [Q_W-1];
  logic [DEN_W-1:0] den_q [Q_W-1];
  logic [Q_W-1:0]   qc_q  [Q_W];
  logic [Q_W-1:0]   qr_q  [Q_W];
  div_flags_t       fl_q  [Q_W];
  logic [PAY_W-1:0] pay_q [Q_W];

  assign rdy[Q_W] = out_ready_i;

  for (genvar j = 0; j < Q_W; j++) begin : g_stage
    logic [CMP_W-1:0] rc_in;
    logic [CMP_W-1:0] rr_in;
    logic [DEN_W-1:0] dn_in;
    logic [Q_W-1:0]   qc_in;
    logic [Q_W-1:0]   qr_in;
    div_flags_t       fl_in;
    logic [PAY_W-1:0] pay_in;
    logic             v_in;
    logic [CMP_W-1:0] dsh;
    logic             ge_c;
    logic             ge_r;

    // Stage inputs come from the ports or from the previous stage.
    if (j == 0) begin : g_first
      assign rc_in          = CMP_W'(num_col_i);
      assign rr_in          = CMP_W'(num_row_i);
      assign dn_in          = den_i;
      assign qc_in          = '0;
      assign qr_in          = '0;
      assign fl_in.ovf_col  = CMP_W'(num_col_i) >= (CMP_W'(den_i) << Q_W);
      assign fl_in.ovf_row  = CMP_W'(num_row_i) >= (CMP_W'(den_i) << Q_W);
      assign pay_in         = pay_i;
      assign v_in           = in_valid_i;
    end else begin : g_next
      assign rc_in  = rc_q[j-1];
      assign rr_in  = rr_q[j-1];
      assign dn_in  = den_q[j-1];
      assign qc_in  = qc_q[j-1];
      assign qr_in  = qr_q[j-1];
      assign fl_in  = fl_q[j-1];
      assign pay_in = pay_q[j-1];
      assign v_in   = v_q[j-1];
    end

    // A stage takes a new item when it is empty or its item moves on.
    assign rdy[j] = !v_q[j] || rdy[j+1];

    // Trial subtraction for this quotient bit.
    assign dsh  = CMP_W'(dn_in) << (Q_W - 1 - j);
    assign ge_c = rc_in >= dsh;
    assign ge_r = rr_in >= dsh;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[j] <= 1'b0;
      end else if (rdy[j]) begin
        v_q[j] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[j]) begin
        qc_q[j]  <= qc_in | (Q_W'(ge_c) << (Q_W - 1 - j));
        qr_q[j]  <= qr_in | (Q_W'(ge_r) << (Q_W - 1 - j));
        fl_q[j]  <= fl_in;
        pay_q[j] <= pay_in;
      end
    end

    // The last stage needs no remainder.
    if (j < Q_W - 1) begin : g_rem
      always_ff @(posedge clk_i) begin
        if (rdy[j]) begin
          rc_q[j]  <= ge_c ? rc_in - dsh : rc_in;
          rr_q[j]  <= ge_r ? rr_in - dsh : rr_in;
          den_q[j] <= dn_in;
        end
      end
    end
  end

  assign in_ready_o  = rdy[0];
  assign out_valid_o = v_q[Q_W-1];
  assign q_col_o     = qc_q[Q_W-1];
  assign q_row_o     = qr_q[Q_W-1];
  assign flags_o     = fl_q[Q_W-1];
  assign pay_o       = pay_q[Q_W-1];

endmodule

@@ rtl/core/lidar_point_camera_projection.sv @@
// -----------------------------------------------------------------------------
// lidar_point_camera_projection: lidar point to camera pixel projection
// Rigid transform into the camera frame, depth and range culling, pinhole
// projection and a rainbow color from intensity.
// -----------------------------------------------------------------------------
// The block accepts one lidar point per clock while in_ready_o is high and
// emits zero or one pixel per point, in input order. The pipeline has one
// stage for the nine rotation products, one for the sums and translation,
// one for the range squares and projection products, one for the numerator
// sums and range test, one for the numerator magnitudes, then one stage per
// quotient bit in the column/row divider, and the output register. Each
// stage holds its item under backpressure, so bubbles close up and a
// stalled output does not stop earlier stages from filling.
module lidar_point_camera_projection #(
  parameter int unsigned IMAGE_DIM_BITS  = 13,
  parameter int unsigned COEFF_FRAC_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // Configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [lpcp_pkg::REG_ADDR_W-1:0]       paddr,
  input  logic [lpcp_pkg::CFG_DATA_W-1:0]       pwdata,
  output logic [lpcp_pkg::CFG_DATA_W-1:0]       prdata,
  output logic                                  pready,
  // Input channel
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [lpcp_pkg::POINT_W-1:0]   point_x_mm_i,
  input  logic signed [lpcp_pkg::POINT_W-1:0]   point_y_mm_i,
  input  logic signed [lpcp_pkg::POINT_W-1:0]   point_z_mm_i,
  input  logic [lpcp_pkg::INTENS_W-1:0]         intensity_i,
  input  logic                                  point_valid_i,
  // Output channel
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [IMAGE_DIM_BITS-1:0]             pixel_column_o,
  output logic [IMAGE_DIM_BITS-1:0]             pixel_row_o,
  output logic [7:0]                            red_o,
  output logic [7:0]                            green_o,
  output logic [7:0]                            blue_o
);
  import lpcp_pkg::*;

  localparam int unsigned ROW_W  = 3 * COEFF_W;
  localparam int unsigned IMG_W  = 2 * IMAGE_DIM_BITS;
  localparam int unsigned PROD_W = COEFF_W + POINT_W;
  localparam int unsigned ACC_W  =
    ((TRANS_W + COEFF_FRAC_BITS > PROD_W) ? TRANS_W + COEFF_FRAC_BITS : PROD_W) + 2;
  localparam int unsigned SH_W   = COEFF_FRAC_BITS - CAM_FRAC;
  localparam int unsigned CAM_W  = ACC_W - SH_W;
  localparam int unsigned MM_W   = CAM_W - CAM_FRAC;
  localparam int unsigned SQ_W   = 2 * RANGE_W;
  localparam int unsigned D2_W   = SQ_W + 2;
  localparam int unsigned PX_W   = INTR_W + 1 + CAM_W;
  localparam int unsigned NUM_W  = PX_W + 1;
  localparam int unsigned DZ_W   = CAM_W - 1;
  localparam int unsigned DEN_W  = DZ_W + CAM_FRAC;
  localparam int unsigned PAY_W  = $bits(rgb_t) + 2;
  localparam logic [SQ_W-1:0] LIM_RESET = SQ_W'(RANGE_RESET) * SQ_W'(RANGE_RESET);

  // ---------------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------------
  logic [ROW_W-1:0]     rot_q [3];
  logic [3*TRANS_W-1:0] trans_q;
  logic [2*INTR_W-1:0]  focal_q;
  logic [2*INTR_W-1:0]  pp_q;
  logic [RANGE_W-1:0]   max_range_q;
  logic [IMG_W-1:0]     image_q;
  logic [SQ_W-1:0]      lim_q;
  reg_idx_e             reg_idx;
  logic                 cfg_wr;

  assign reg_idx = reg_idx_e'(paddr[REG_ADDR_W-1:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign pready  = 1'b1;

  // Register writes, truncated to each register's width.
  // Only 41 bits of each 42-bit intrinsics register are written, so the top bit of fy and cy
  // always reads as zero.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rot_q[0]    <= '0;
      rot_q[1]    <= '0;
      rot_q[2]    <= '0;
      trans_q     <= '0;
      focal_q     <= '0;
      pp_q        <= '0;
      max_range_q <= RANGE_RESET;
      image_q     <= '0;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_ROT_X:      rot_q[0]    <= pwdata[ROW_W-1:0];
        REG_ROT_Y:      rot_q[1]    <= pwdata[ROW_W-1:0];
        REG_ROT_Z:      rot_q[2]    <= pwdata[ROW_W-1:0];
        REG_TRANS:      trans_q     <= pwdata[3*TRANS_W-1:0];
        REG_FOCAL:      focal_q     <= {1'b0, pwdata[2*INTR_W-2:0]};
        REG_PRINCIPAL:  pp_q        <= {1'b0, pwdata[2*INTR_W-2:0]};
        REG_MAX_RANGE:  max_range_q <= pwdata[RANGE_W-1:0];
        REG_IMAGE_SIZE: image_q     <= pwdata[IMG_W-1:0];
        default: ;
      endcase
    end
  end

  // Squared range limit, refreshed every cycle from the register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lim_q <= LIM_RESET;
    end else begin
      lim_q <= SQ_W'(max_range_q) * SQ_W'(max_range_q);
    end
  end

  // Register read-back.
  always_comb begin
    case (reg_idx)
      REG_ROT_X:      prdata = CFG_DATA_W'(rot_q[0]);
      REG_ROT_Y:      prdata = CFG_DATA_W'(rot_q[1]);
      REG_ROT_Z:      prdata = CFG_DATA_W'(rot_q[2]);
      REG_TRANS:      prdata = CFG_DATA_W'(trans_q);
      REG_FOCAL:      prdata = CFG_DATA_W'(focal_q);
      REG_PRINCIPAL:  prdata = CFG_DATA_W'(pp_q);
      REG_MAX_RANGE:  prdata = CFG_DATA_W'(max_range_q);
      REG_IMAGE_SIZE: prdata = CFG_DATA_W'(image_q);
      default:        prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control: stages 1 to 5, then the divider
  // ---------------------------------------------------------------------------
  logic [5:1] v_q;
  logic [6:1] en;
  logic       keep3;
  logic       keep4;
  logic       div_in_ready;
  logic       div_valid;
  logic       out_en;

  assign en[6] = div_in_ready;
  for (genvar s = 1; s <= 5; s++) begin : g_ctl
    assign en[s] = !v_q[s] || en[s+1];
  end
  assign in_ready_o = en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[1]) v_q[1] <= in_valid_i && point_valid_i;
      if (en[2]) v_q[2] <= v_q[1];
      if (en[3]) v_q[3] <= v_q[2] && keep3;
      if (en[4]) v_q[4] <= v_q[3] && keep4;
      if (en[5]) v_q[5] <= v_q[4];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: rotation products and color lookup
  // ---------------------------------------------------------------------------
  logic signed [POINT_W-1:0] pt [3];
  logic signed [PROD_W-1:0]  prod_d [3][3];
  logic signed [PROD_W-1:0]  prod_q [3][3];
  rgb_t                      rgb1_q;

  assign pt[0] = point_x_mm_i;
  assign pt[1] = point_y_mm_i;
  assign pt[2] = point_z_mm_i;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        prod_d[r][c] = $signed(rot_q[r][COEFF_W*c +: COEFF_W]) * pt[c];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      prod_q <= prod_d;
      rgb1_q <= RAINBOW_LUT[intensity_i];
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: sums plus translation, floored to 8 fraction bits
  // ---------------------------------------------------------------------------
  logic signed [ACC_W-1:0] acc [3];
  logic signed [CAM_W-1:0] cam_q [3];
  rgb_t                    rgb2_q;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = (ACC_W'($signed(trans_q[TRANS_W*r +: TRANS_W])) <<< COEFF_FRAC_BITS)
             + ACC_W'(prod_q[r][0]) + ACC_W'(prod_q[r][1]) + ACC_W'(prod_q[r][2]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      for (int r = 0; r < 3; r++) begin
        cam_q[r] <= acc[r][ACC_W-1:SH_W];
      end
      rgb2_q <= rgb1_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: depth test, range squares and projection products
  // ---------------------------------------------------------------------------
  logic [MM_W-1:0]         mm   [3];
  logic [MM_W-1:0]         mag  [3];
  logic [SQ_W-1:0]         sq_d [3];
  logic [SQ_W-1:0]         sq_q [3];
  logic                    far_d;
  logic                    far_q;
  logic signed [PX_W-1:0]  pxa_q;
  logic signed [PX_W-1:0]  pxb_q;
  logic signed [PX_W-1:0]  pya_q;
  logic signed [PX_W-1:0]  pyb_q;
  logic [DZ_W-1:0]         dz3_q;
  rgb_t                    rgb3_q;

  assign keep3 = !cam_q[2][CAM_W-1] && (|cam_q[2]);

  // Magnitudes beyond the range register width always fail the range test.
  always_comb begin
    far_d = 1'b0;
    for (int r = 0; r < 3; r++) begin
      mm[r]   = cam_q[r][CAM_W-1:CAM_FRAC];
      mag[r]  = mm[r][MM_W-1] ? -mm[r] : mm[r];
      far_d   = far_d | (|mag[r][MM_W-1:RANGE_W]);
      sq_d[r] = SQ_W'(mag[r][RANGE_W-1:0]) * SQ_W'(mag[r][RANGE_W-1:0]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[3]) begin
      sq_q   <= sq_d;
      far_q  <= far_d;
      pxa_q  <= $signed({1'b0, focal_q[INTR_W-1:0]}) * cam_q[0];
      pxb_q  <= $signed({1'b0, pp_q[INTR_W-1:0]}) * cam_q[2];
      pya_q  <= $signed({1'b0, focal_q[2*INTR_W-1:INTR_W]}) * cam_q[1];
      pyb_q  <= $signed({1'b0, pp_q[2*INTR_W-1:INTR_W]}) * cam_q[2];
      dz3_q  <= cam_q[2][DZ_W-1:0];
      rgb3_q <= rgb2_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: range test and projection numerators
  // ---------------------------------------------------------------------------
  logic [D2_W-1:0]         d2;
  logic signed [NUM_W-1:0] numc_q;
  logic signed [NUM_W-1:0] numr_q;
  logic [DZ_W-1:0]         dz4_q;
  rgb_t                    rgb4_q;

  assign d2    = D2_W'(sq_q[0]) + D2_W'(sq_q[1]) + D2_W'(sq_q[2]);
  assign keep4 = !far_q && (d2 <= D2_W'(lim_q));

  always_ff @(posedge clk_i) begin
    if (en[4]) begin
      numc_q <= NUM_W'(pxa_q) + NUM_W'(pxb_q);
      numr_q <= NUM_W'(pya_q) + NUM_W'(pyb_q);
      dz4_q  <= dz3_q;
      rgb4_q <= rgb3_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 5: numerator signs and magnitudes
  // ---------------------------------------------------------------------------
  logic [NUM_W-1:0] magc_q;
  logic [NUM_W-1:0] magr_q;
  logic             negc_q;
  logic             negr_q;
  logic [DZ_W-1:0]  dz5_q;
  rgb_t             rgb5_q;

  always_ff @(posedge clk_i) begin
    if (en[5]) begin
      negc_q <= numc_q[NUM_W-1];
      negr_q <= numr_q[NUM_W-1];
      magc_q <= numc_q[NUM_W-1] ? -numc_q : numc_q;
      magr_q <= numr_q[NUM_W-1] ? -numr_q : numr_q;
      dz5_q  <= dz4_q;
      rgb5_q <= rgb4_q;
    end
  end

  // ---------------------------------------------------------------------------
  // Column and row division by depth times 256
  // ---------------------------------------------------------------------------
  logic [IMAGE_DIM_BITS-1:0] qc;
  logic [IMAGE_DIM_BITS-1:0] qr;
  div_flags_t                dflags;
  logic [PAY_W-1:0]          dpay;
  logic                      dnegc;
  logic                      dnegr;
  rgb_t                      drgb;

  lpcp_div #(
    .MAG_W (NUM_W),
    .DEN_W (DEN_W),
    .Q_W   (IMAGE_DIM_BITS),
    .PAY_W (PAY_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v_q[5]),
    .in_ready_o  (div_in_ready),
    .num_col_i   (magc_q),
    .num_row_i   (magr_q),
    .den_i       ({dz5_q, CAM_FRAC'(0)}),
    .pay_i       ({negc_q, negr_q, rgb5_q}),
    .out_valid_o (div_valid),
    .out_ready_i (out_en),
    .q_col_o     (qc),
    .q_row_o     (qr),
    .flags_o     (dflags),
    .pay_o       (dpay)
  );

  assign {dnegc, dnegr, drgb} = dpay;

  // ---------------------------------------------------------------------------
  // Output register: inside-image test
  // ---------------------------------------------------------------------------
  logic                      in_image;
  logic                      out_v_q;
  logic [IMAGE_DIM_BITS-1:0] col_q;
  logic [IMAGE_DIM_BITS-1:0] row_q;
  rgb_t                      rgb_q;

  // A negative quotient survives only when it truncates to zero.
  assign in_image = !dflags.ovf_col && !dflags.ovf_row
                 && !(dnegc && (|qc)) && !(dnegr && (|qr))
                 && (qc < image_q[IMAGE_DIM_BITS-1:0])
                 && (qr < image_q[IMG_W-1:IMAGE_DIM_BITS]);

  assign out_en = !out_v_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= div_valid && in_image;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en) begin
      col_q <= qc;
      row_q <= qr;
      rgb_q <= drgb;
    end
  end

  assign out_valid_o    = out_v_q;
  assign pixel_column_o = col_q;
  assign pixel_row_o    = row_q;
  assign red_o          = rgb_q.red;
  assign green_o        = rgb_q.green;
  assign blue_o         = rgb_q.blue;

`ifndef NO_ASSERTIONS
  // An invalid point never enters the pipeline.
  a_drop_invalid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && !point_valid_i |=> !v_q[1])
    else $error("invalid point entered the pipeline");

  // Items past the depth test carry a positive depth.
  a_depth_positive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q[4] |-> (dz4_q != '0))
    else $error("item with zero depth past the depth test");

  // An emitted pixel lies inside the configured image.
  a_pixel_inside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pixel_column_o < image_q[IMAGE_DIM_BITS-1:0])
                 && (pixel_row_o < image_q[IMG_W-1:IMAGE_DIM_BITS]))
    else $error("pixel outside the image");

  // Every rainbow color has one channel at full scale.
  a_color_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (red_o == 8'hFF) || (green_o == 8'hFF) || (blue_o == 8'hFF))
    else $error("color without a full-scale channel");
`endif

endmodule

@@ bench/lidar_point_camera_projection_tb.sv @@
// -----------------------------------------------------------------------------
// lidar_point_camera_projection_tb: self-checking bench for point projection
// Streams lidar points through several calibration settings and idle
// patterns, predicts each pixel in the bench and checks every output item.
// -----------------------------------------------------------------------------
`timescale 1ns / 100ps

module lidar_point_camera_projection_tb;
  import lpcp_pkg::*;

  localparam int unsigned DIM_W = 13;
  localparam int unsigned SETTLE_CYCLES = 40;
  localparam logic [17:0] Q_ONE = 18'h10000;
  localparam logic [17:0] Q_NEG_ONE = 18'h30000;

  typedef struct {
    logic signed [POINT_W-1:0] x;
    logic signed [POINT_W-1:0] y;
    logic signed [POINT_W-1:0] z;
    logic [7:0]                intensity;
    logic                      valid;
  } lidar_point_t;

  typedef struct {
    logic [DIM_W-1:0] col;
    logic [DIM_W-1:0] row;
    logic [7:0]       red;
    logic [7:0]       green;
    logic [7:0]       blue;
  } pixel_t;

  logic                     clk_i;
  logic                     rst_ni;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [REG_ADDR_W-1:0]    paddr;
  logic [CFG_DATA_W-1:0]    pwdata;
  logic [CFG_DATA_W-1:0]    prdata;
  logic                     pready;
  logic                     in_valid_i;
  logic                     in_ready_o;
  logic signed [POINT_W-1:0] point_x_mm_i;
  logic signed [POINT_W-1:0] point_y_mm_i;
  logic signed [POINT_W-1:0] point_z_mm_i;
  logic [7:0]               intensity_i;
  logic                     point_valid_i;
  logic                     out_valid_o;
  logic                     out_ready_i;
  logic [DIM_W-1:0]         pixel_column_o;
  logic [DIM_W-1:0]         pixel_row_o;
  logic [7:0]               red_o;
  logic [7:0]               green_o;
  logic [7:0]               blue_o;

  lidar_point_camera_projection dut (.*);

  // Bench copy of the calibration registers.
  logic [63:0]  calib [8];
  lidar_point_t point_q [$];
  pixel_t       pixel_q [$];
  int           send_idle_pct;
  int           recv_stall_pct;
  int           hold_req;
  int           hold_seen;
  int           hold_left;
  int           errors;
  int           points_sent;
  int           pixels_seen;
  bit           axis_swap;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Projects one point with the current calibration; returns 1 if a pixel results.
  function automatic bit project_point(input lidar_point_t pt, output pixel_t px);
    longint p[3];
    longint cam[3];
    longint acc;
    longint d2;
    longint lim;
    longint mm;
    longint fx, fy, cx, cy, den, col, row, width, height;
    int     k, t, seg, rem, a, n;
    px = '{default: '0};
    if (!pt.valid) return 0;
    p[0] = pt.x;
    p[1] = pt.y;
    p[2] = pt.z;
    for (int r = 0; r < 3; r++) begin
      acc = longint'($signed(calib[REG_TRANS][21*r +: 21])) * 65536;
      for (int c = 0; c < 3; c++)
        acc += longint'($signed(calib[r][18*c +: 18])) * p[c];
      cam[r] = acc >>> 8;
    end
    if (cam[2] <= 0) return 0;
    d2 = 0;
    for (int r = 0; r < 3; r++) begin
      mm = cam[r] >>> 8;
      d2 += mm * mm;
    end
    lim = longint'(calib[REG_MAX_RANGE]) * longint'(calib[REG_MAX_RANGE]);
    if (d2 > lim) return 0;
    fx = longint'(calib[REG_FOCAL] & 64'h1FFFFF);
    fy = longint'((calib[REG_FOCAL] >> 21) & 64'h1FFFFF);
    cx = longint'(calib[REG_PRINCIPAL] & 64'h1FFFFF);
    cy = longint'((calib[REG_PRINCIPAL] >> 21) & 64'h1FFFFF);
    den = cam[2] * 256;
    col = (fx * cam[0] + cx * cam[2]) / den;
    row = (fy * cam[1] + cy * cam[2]) / den;
    width = longint'(calib[REG_IMAGE_SIZE] & 64'h1FFF);
    height = longint'((calib[REG_IMAGE_SIZE] >> 13) & 64'h1FFF);
    if (col < 0 || row < 0 || col >= width || row >= height) return 0;
    // Five-segment hue ramp over intensity.
    k = (pt.intensity == 0) ? 0 : int'(pt.intensity) - 1;
    if (k > 179) k = 179;
    t = 5 * k;
    seg = 1 + t / 179;
    rem = t % 179;
    a = (seg % 2 == 1) ? rem : 179 - rem;
    n = 255 * (179 - a) / 179;
    case (seg)
      1: begin px.red = n[7:0]; px.green = 8'd0; px.blue = 8'd255; end
      2: begin px.red = 8'd0; px.green = n[7:0]; px.blue = 8'd255; end
      3: begin px.red = 8'd0; px.green = 8'd255; px.blue = n[7:0]; end
      4: begin px.red = n[7:0]; px.green = 8'd255; px.blue = 8'd0; end
      default: begin px.red = 8'd255; px.green = n[7:0]; px.blue = 8'd0; end
    endcase
    px.col = col[DIM_W-1:0];
    px.row = row[DIM_W-1:0];
    return 1;
  endfunction

  // Sender: predicts each accepted item, then offers the next one or idles.
  always @(posedge clk_i or negedge rst_ni) begin
    pixel_t       px;
    lidar_point_t pt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && in_ready_o) begin
        pt = '{x: point_x_mm_i, y: point_y_mm_i, z: point_z_mm_i,
               intensity: intensity_i, valid: point_valid_i};
        points_sent++;
        if (project_point(pt, px)) pixel_q = {pixel_q, px};
      end
      if (!in_valid_i || in_ready_o) begin
        if (point_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          pt = point_q.pop_front();
          in_valid_i    <= 1'b1;
          point_x_mm_i  <= pt.x;
          point_y_mm_i  <= pt.y;
          point_z_mm_i  <= pt.z;
          intensity_i   <= pt.intensity;
          point_valid_i <= pt.valid;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Receiver: random stalls plus an occasional long hold-off.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      hold_left = 0;
      hold_seen = 0;
    end else begin
      if (hold_seen != hold_req) begin
        hold_seen = hold_req;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Output checker against the oldest predicted pixel.
  always @(posedge clk_i) begin
    pixel_t px;
    if (rst_ni && out_valid_o && out_ready_i) begin
      pixels_seen++;
      if (pixel_q.size() == 0) begin
        $display("%0t: unexpected pixel col=%0d row=%0d", $time, pixel_column_o, pixel_row_o);
        errors++;
      end else begin
        px = pixel_q.pop_front();
        if (px.col !== pixel_column_o) begin
          $display("%0t: column expected %0d actual %0d", $time, px.col, pixel_column_o);
          errors++;
        end
        if (px.row !== pixel_row_o) begin
          $display("%0t: row expected %0d actual %0d", $time, px.row, pixel_row_o);
          errors++;
        end
        if (px.red !== red_o) begin
          $display("%0t: red expected %0d actual %0d", $time, px.red, red_o);
          errors++;
        end
        if (px.green !== green_o) begin
          $display("%0t: green expected %0d actual %0d", $time, px.green, green_o);
          errors++;
        end
        if (px.blue !== blue_o) begin
          $display("%0t: blue expected %0d actual %0d", $time, px.blue, blue_o);
          errors++;
        end
      end
    end
  end

  // Register write: setup cycle, then access cycle.
  task automatic write_reg(input reg_idx_e idx, input logic [63:0] value);
    int widths[8] = '{54, 54, 54, 63, 41, 41, 18, 26};
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= REG_ADDR_W'(int'(idx) * 8);
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    calib[idx] = value & ((64'd1 << widths[idx]) - 1);
  endtask

  task automatic load_calibration(input logic [63:0] rx, input logic [63:0] ry,
                                  input logic [63:0] rz, input logic [63:0] tr,
                                  input logic [63:0] foc, input logic [63:0] pp,
                                  input logic [63:0] rng, input logic [63:0] img);
    write_reg(REG_ROT_X, rx);
    write_reg(REG_ROT_Y, ry);
    write_reg(REG_ROT_Z, rz);
    write_reg(REG_TRANS, tr);
    write_reg(REG_FOCAL, foc);
    write_reg(REG_PRINCIPAL, pp);
    write_reg(REG_MAX_RANGE, rng);
    write_reg(REG_IMAGE_SIZE, img);
  endtask

  // Waits until every queued item is taken and every pixel has come out.
  task automatic drain();
    do @(posedge clk_i);
    while (point_q.size() != 0 || in_valid_i || pixel_q.size() != 0);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic add_point(input int x, input int y, input int z,
                           input int inten, input bit valid);
    lidar_point_t pt;
    pt.x = POINT_W'(x);
    pt.y = POINT_W'(y);
    pt.z = POINT_W'(z);
    pt.intensity = inten[7:0];
    pt.valid = valid;
    point_q = {point_q, pt};
  endtask

  // A point that lands in a typical image, given in camera axes.
  task automatic add_visible_point();
    int zc, xc, yc, w;
    zc = $urandom_range(14000, 300);
    w = zc * 6 / 10;
    xc = int'($urandom_range(2 * w)) - w;
    w = zc * 45 / 100;
    yc = int'($urandom_range(2 * w)) - w;
    if (axis_swap) add_point(zc, -xc, -yc, $urandom_range(255), $urandom_range(19) != 0);
    else add_point(xc, yc, zc, $urandom_range(255), $urandom_range(19) != 0);
  endtask

  task automatic add_noise_point();
    add_point($urandom, $urandom, $urandom, $urandom, $urandom_range(1) != 0);
  endtask

  task automatic add_mixed(input int count);
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(9) < 8) add_visible_point();
      else add_noise_point();
    end
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  logic [63:0] ident_x, ident_y, ident_z, pinhole_f, pinhole_c, vga;

  initial begin
    int intens[10] = '{0, 1, 36, 37, 72, 108, 144, 180, 181, 255};
    errors = 0;
    points_sent = 0;
    pixels_seen = 0;
    hold_req = 0;
    axis_swap = 1'b0;
    set_idling(0, 0);
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_valid_i = 1'b0;
    point_x_mm_i = '0;
    point_y_mm_i = '0;
    point_z_mm_i = '0;
    intensity_i = '0;
    point_valid_i = 1'b0;
    out_ready_i = 1'b0;
    for (int i = 0; i < 8; i++) calib[i] = 64'd0;
    calib[REG_MAX_RANGE] = 64'd15000;
    ident_x = {28'd0, 18'd0, 18'd0, Q_ONE};
    ident_y = {28'd0, 18'd0, Q_ONE, 18'd0};
    ident_z = {28'd0, Q_ONE, 18'd0, 18'd0};
    pinhole_f = {22'd0, 21'(500 * 256), 21'(500 * 256)};
    pinhole_c = {22'd0, 21'(240 * 256), 21'(320 * 256)};
    vga = {38'd0, 13'd480, 13'd640};
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Points right after reset: all-zero calibration drops every one.
    add_point(100, 0, 1000, 50, 1'b1);
    add_point(-262144, 262143, 5, 255, 1'b1);
    drain();

    // Directed: drops, extremes and every color segment.
    load_calibration(ident_x, ident_y, ident_z, 64'd0, pinhole_f, pinhole_c, 64'd15000, vga);
    add_point(0, 0, 2000, 100, 1'b0);
    add_point(0, 0, 0, 100, 1'b1);
    add_point(0, 0, -2000, 100, 1'b1);
    add_point(0, 0, 16000, 100, 1'b1);
    add_point(5000, 0, 1000, 100, 1'b1);
    add_point(-5000, -5000, 1000, 100, 1'b1);
    add_point(-262144, -262144, -262144, 0, 1'b1);
    add_point(262143, 262143, 262143, 255, 1'b1);
    add_point(-1, 0, 3000, 128, 1'b1);
    foreach (intens[i]) add_point(i * 100 - 500, 50 - i * 20, 3000 + i * 200, intens[i], 1'b1);
    drain();

    // Identity mount, no idling.
    set_idling(0, 0);
    add_mixed(220);
    drain();

    // Sender idles often; the receiver holds off long while items keep coming.
    set_idling(55, 0);
    add_mixed(110);
    hold_req++;
    add_mixed(110);
    drain();

    // Rotated mount with offset, receiver stalls; mid-phase the sender waits out.
    axis_swap = 1'b1;
    load_calibration({28'd0, 18'd0, Q_NEG_ONE, 18'd0}, {28'd0, Q_NEG_ONE, 18'd0, 18'd0},
                     {28'd0, 18'd0, 18'd0, Q_ONE}, {1'b0, 21'd100, 21'h1FFFCE, 21'd30},
                     pinhole_f, pinhole_c, 64'd15000, vga);
    set_idling(0, 55);
    add_mixed(120);
    do @(posedge clk_i);
    while (point_q.size() != 0 || in_valid_i || pixel_q.size() != 0);
    add_mixed(120);
    drain();

    // Largest image and range, both sides idle rarely.
    axis_swap = 1'b0;
    load_calibration(ident_x, ident_y, ident_z, 64'd0,
                     {22'd0, 21'(4000 * 256), 21'(4000 * 256)},
                     {22'd0, 21'(4095 * 256), 21'(4095 * 256)},
                     64'd262143, {38'd0, 13'd8191, 13'd8191});
    set_idling(6, 6);
    add_mixed(220);
    drain();

    // Random calibrations with noise and visible points.
    set_idling(20, 20);
    for (int i = 0; i < 3; i++) begin
      load_calibration({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
                       {$urandom, $urandom}, {$urandom, $urandom});
      add_mixed(40);
      drain();
    end

    // Every register at its all-ones value.
    load_calibration('1, '1, '1, '1, '1, '1, '1, '1);
    add_mixed(30);
    drain();

    // Zero intrinsics: every surviving point maps to the corner pixel.
    load_calibration(ident_x, ident_y, ident_z, 64'd0, 64'd0, 64'd0, 64'd262143, 64'd8193);
    set_idling(0, 0);
    add_mixed(220);
    drain();

    // Empty image and zero range limit: nothing is emitted.
    load_calibration(ident_x, ident_y, ident_z, 64'd0, pinhole_f, pinhole_c, 64'd15000,
                     {38'd0, 13'd480, 13'd0});
    add_mixed(30);
    drain();
    write_reg(REG_IMAGE_SIZE, vga);
    write_reg(REG_MAX_RANGE, 64'd0);
    add_mixed(30);
    drain();

    if (pixel_q.size() != 0) begin
      $display("%0t: %0d expected pixels never arrived", $time, pixel_q.size());
      errors++;
    end
    $display("Projected %0d points under 11 calibrations and 5 idle patterns;", points_sent);
    $display("%0d pixels checked, %0d mismatches.", pixels_seen, errors);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5000000;
    $display("FAIL");
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/lpcp_pkg.sv
rtl/core/lpcp_div.sv
rtl/core/lidar_point_camera_projection.sv
bench/lidar_point_camera_projection_tb.sv
